@@ rtl/mlr_pkg.sv @@
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants of the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

   // Screen geometry
   localparam int SCREEN_SIZE = 512;
   localparam int COORD_W     = 9;
   localparam int DELTA_W     = 10;
   localparam int DECISION_W  = 12;
   localparam int ADDR_W      = 18;
   localparam int COLOR_W     = 24;

   // Stream payload widths
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 64;

   // Request kinds
   typedef enum logic [0:0] {
      KIND_LOAD = 1'b0,
      KIND_STEP = 1'b1
   } kind_type;

   // One request after unpacking
   typedef struct packed {
      kind_type             kind;
      logic [COORD_W-1:0]   x_start;
      logic [COORD_W-1:0]   y_start;
      logic [COORD_W-1:0]   x_end;
      logic [COORD_W-1:0]   y_end;
      logic [COLOR_W-1:0]   color;
   } req_item_type;

   // One plotted pixel
   typedef struct packed {
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [ADDR_W-1:0]    address;
      logic [COLOR_W-1:0]   color;
      logic                 last;
   } pixel_type;

endpackage

@@ rtl/midpoint_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line engine for all octants with a linear frame-buffer address.
// ----------------------------------------------------------------------------
// Takes one request per clock and, when a step request hits an active line,
// returns one pixel per clock. A load request (tuser 0) sets up a new line
// and gives no result; a step request (tuser 1) gives the next pixel, with
// tlast on the far endpoint; a step with no line active gives nothing.
// Each request is held in the input register, then passes the line state
// update into the result register, from which its pixel is driven on rsp;
// downstream backpressure stalls the input through the result register.
module midpoint_line_rasterizer
   import mlr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [8:0] x_start, [17:9] y_start, [26:18] x_end, [35:27] y_end,
   // [59:36] color, [63:60] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] kind
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [8:0] pixel_x, [17:9] pixel_y, [35:18] pixel_address,
   // [59:36] pixel_color, [63:60] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic         item_valid;
   logic         item_fire;
   logic         stage_ready;
   logic         pixel_emit;
   req_item_type item;
   pixel_type    pixel;

   // Consume the held request when the result side can take its pixel
   assign item_fire = item_valid && stage_ready;

   mlr_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_take  (item_fire),
      .item_valid (item_valid),
      .item       (item)
   );

   mlr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_fire  (item_fire),
      .item       (item),
      .pixel_emit (pixel_emit),
      .pixel      (pixel)
   );

   mlr_rsp_stage u_rsp_stage (
      .clock       (clock),
      .reset       (reset),
      .pixel_emit  (pixel_emit),
      .pixel       (pixel),
      .stage_ready (stage_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ rtl/mlr_req_stage.sv @@
// ----------------------------------------------------------------------------
// mlr_req_stage
// Input register: captures one request per cycle and holds it until the
// line core consumes it.
// ----------------------------------------------------------------------------
module mlr_req_stage
   import mlr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  item_take,
   output logic                  item_valid,
   output req_item_type          item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   req_item_type item_in;

   // Accept when empty or when the held request leaves this cycle
   assign req_tready = !valid_ff || item_take;

   // Unpack the stream payload
   always_comb begin
      item_in         = item_ff;
      valid_in        = valid_ff && !item_take;
      if (req_tvalid && req_tready) begin
         valid_in        = 1'b1;
         item_in.kind    = kind_type'(req_tuser);
         item_in.x_start = req_tdata[8:0];
         item_in.y_start = req_tdata[17:9];
         item_in.x_end   = req_tdata[26:18];
         item_in.y_end   = req_tdata[35:27];
         item_in.color   = req_tdata[59:36];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/mlr_core.sv @@
// ----------------------------------------------------------------------------
// mlr_core
// Line state and midpoint step logic: sets up a line on load and walks one
// pixel per step request.
// ----------------------------------------------------------------------------
module mlr_core
   import mlr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_fire,
   input  req_item_type item,
   output logic         pixel_emit,
   output pixel_type    pixel
);

   logic [COORD_W-1:0]    cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]    cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]    stop_x_ff, stop_x_in;
   logic [COORD_W-1:0]    stop_y_ff, stop_y_in;
   logic [DELTA_W-1:0]    delta_major_ff, delta_major_in;
   logic [DELTA_W-1:0]    delta_minor_ff, delta_minor_in;
   logic [DECISION_W-1:0] decision_ff, decision_in;
   logic                  major_y_ff, major_y_in;
   logic                  y_down_ff, y_down_in;
   logic [COLOR_W-1:0]    line_color_ff, line_color_in;
   logic                  active_ff, active_in;

   // Load setup terms
   logic                  swap;
   logic [COORD_W-1:0]    xa, ya, xb, yb;
   logic [COORD_W-1:0]    dx, ady;
   logic                  dy_neg, steep;
   logic [DELTA_W-1:0]    ld_major, ld_minor;

   // Step terms
   logic                  is_last, minor_step;
   logic [DECISION_W-1:0] inc_diag, inc_flat;
   logic [COORD_W-1:0]    x_inc, y_move;

   // Order endpoints by column, then row, and derive extents
   always_comb begin
      swap     = (item.x_start > item.x_end) ||
                 ((item.x_start == item.x_end) && (item.y_start > item.y_end));
      xa       = swap ? item.x_end   : item.x_start;
      ya       = swap ? item.y_end   : item.y_start;
      xb       = swap ? item.x_start : item.x_end;
      yb       = swap ? item.y_start : item.y_end;
      dx       = xb - xa;
      dy_neg   = yb < ya;
      ady      = dy_neg ? (ya - yb) : (yb - ya);
      steep    = ady > dx;
      ld_major = {1'b0, (steep ? ady : dx)};
      ld_minor = {1'b0, (steep ? dx : ady)};
   end

   // Midpoint step on the current pixel
   always_comb begin
      is_last    = major_y_ff ? (cur_y_ff == stop_y_ff) : (cur_x_ff == stop_x_ff);
      minor_step = !decision_ff[DECISION_W-1] && (|decision_ff);
      inc_flat   = {1'b0, delta_minor_ff, 1'b0};
      inc_diag   = {1'b0, delta_minor_ff, 1'b0} - {1'b0, delta_major_ff, 1'b0};
      x_inc      = cur_x_ff + COORD_W'(1);
      y_move     = y_down_ff ? (cur_y_ff - COORD_W'(1)) : (cur_y_ff + COORD_W'(1));
   end

   // Next state
   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      stop_x_in      = stop_x_ff;
      stop_y_in      = stop_y_ff;
      delta_major_in = delta_major_ff;
      delta_minor_in = delta_minor_ff;
      decision_in    = decision_ff;
      major_y_in     = major_y_ff;
      y_down_in      = y_down_ff;
      line_color_in  = line_color_ff;
      active_in      = active_ff;
      if (item_fire) begin
         case (item.kind)
            KIND_LOAD: begin
               cur_x_in       = xa;
               cur_y_in       = ya;
               stop_x_in      = xb;
               stop_y_in      = yb;
               delta_major_in = ld_major;
               delta_minor_in = ld_minor;
               decision_in    = {1'b0, ld_minor, 1'b0} - {2'b00, ld_major};
               major_y_in     = steep;
               y_down_in      = dy_neg;
               line_color_in  = item.color;
               active_in      = 1'b1;
            end
            KIND_STEP: begin
               if (active_ff) begin
                  if (is_last) begin
                     active_in = 1'b0;
                  end else begin
                     decision_in = decision_ff + (minor_step ? inc_diag : inc_flat);
                     if (major_y_ff) begin
                        cur_y_in = y_move;
                        if (minor_step) cur_x_in = x_inc;
                     end else begin
                        cur_x_in = x_inc;
                        if (minor_step) cur_y_in = y_move;
                     end
                  end
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      stop_x_ff      <= stop_x_in;
      stop_y_ff      <= stop_y_in;
      delta_major_ff <= delta_major_in;
      delta_minor_ff <= delta_minor_in;
      decision_ff    <= decision_in;
      major_y_ff     <= major_y_in;
      y_down_ff      <= y_down_in;
      line_color_ff  <= line_color_in;
   end

   // Drive the current pixel
   always_comb begin
      pixel_emit    = item_fire && (item.kind == KIND_STEP) && active_ff;
      pixel.x       = cur_x_ff;
      pixel.y       = cur_y_ff;
      pixel.address = ADDR_W'(32'(cur_y_ff) * 32'(SCREEN_SIZE) + 32'(cur_x_ff));
      pixel.color   = line_color_ff;
      pixel.last    = is_last;
   end

endmodule

@@ rtl/mlr_rsp_stage.sv @@
// ----------------------------------------------------------------------------
// mlr_rsp_stage
// Result register: holds one pixel until the downstream side takes it.
// ----------------------------------------------------------------------------
module mlr_rsp_stage
   import mlr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pixel_emit,
   input  pixel_type             pixel,
   output logic                  stage_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic      valid_ff, valid_in;
   pixel_type pixel_ff, pixel_in;

   // Free when empty or when the held pixel drains this cycle
   assign stage_ready = !valid_ff || rsp_tready;

   always_comb begin
      pixel_in = pixel_ff;
      valid_in = valid_ff && !rsp_tready;
      if (pixel_emit) begin
         pixel_in = pixel;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   // Pack the result payload
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = pixel_ff.last;
   assign rsp_tdata  = {4'b0000, pixel_ff.color, pixel_ff.address, pixel_ff.y, pixel_ff.x};

endmodule

@@ verif/midpoint_line_rasterizer_tb.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_tb
// Drives load and step requests into the line engine and checks every
// plotted pixel against a midpoint line walk kept in the bench. The bench
// runs directed lines for most octant classes and the corner cases, then
// random lines under changing backpressure on both stream sides.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_tb;
   import mlr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS  = 360;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Line walk state of the bench
   logic [COORD_W-1:0]           walk_x, walk_y, stop_x, stop_y;
   logic [DELTA_W-1:0]           span_major, span_minor;
   logic signed [DECISION_W-1:0] walk_decision;
   logic                         y_major, y_down;
   logic [COLOR_W-1:0]           walk_color;
   logic                         walk_active;

   pixel_type pixel_q[$];
   int        send_idle_pct;
   int        recv_idle_pct;
   int        counted_items;
   int        cycle_count;
   bit        failed;

   midpoint_line_rasterizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_line(input int xs, input int ys,
                                                       input int xe, input int ye,
                                                       input logic [COLOR_W-1:0] color);
      logic [REQ_DATA_W-1:0] data;
      data        = '0;
      data[8:0]   = COORD_W'(xs);
      data[17:9]  = COORD_W'(ys);
      data[26:18] = COORD_W'(xe);
      data[35:27] = COORD_W'(ye);
      data[59:36] = color;
      return data;
   endfunction

   function automatic int clip_coord(input int v);
      if (v < 0) return 0;
      if (v > SCREEN_SIZE - 1) return SCREEN_SIZE - 1;
      return v;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_payload();
      logic [REQ_DATA_W-1:0] data;
      data        = {$urandom, $urandom};
      data[63:60] = '0;
      return data;
   endfunction

   // Apply one accepted request to the line walk; flag a pixel when one is due
   task automatic predict_request(input kind_type kind, input logic [REQ_DATA_W-1:0] data,
                                  output bit made, output pixel_type px);
      int xa, ya, xb, yb, swap_tmp, dx, dy, ady;
      bit at_end, go_minor;
      made = 1'b0;
      px   = '0;
      if (kind == KIND_LOAD) begin
         xa = int'(data[8:0]);
         ya = int'(data[17:9]);
         xb = int'(data[26:18]);
         yb = int'(data[35:27]);
         // Walk from the lower column, or the lower row on a vertical line
         if (xa > xb || (xa == xb && ya > yb)) begin
            swap_tmp = xa; xa = xb; xb = swap_tmp;
            swap_tmp = ya; ya = yb; yb = swap_tmp;
         end
         dx  = xb - xa;
         dy  = yb - ya;
         ady = (dy < 0) ? -dy : dy;
         y_major       = (ady > dx);
         y_down        = (dy < 0);
         span_major    = DELTA_W'(y_major ? ady : dx);
         span_minor    = DELTA_W'(y_major ? dx : ady);
         walk_decision = DECISION_W'(2 * int'(span_minor) - int'(span_major));
         walk_x        = COORD_W'(xa);
         walk_y        = COORD_W'(ya);
         stop_x        = COORD_W'(xb);
         stop_y        = COORD_W'(yb);
         walk_color    = data[59:36];
         walk_active   = 1'b1;
      end else if (walk_active) begin
         at_end     = y_major ? (walk_y == stop_y) : (walk_x == stop_x);
         made       = 1'b1;
         px.x       = walk_x;
         px.y       = walk_y;
         px.address = ADDR_W'(int'(walk_y) * SCREEN_SIZE + int'(walk_x));
         px.color   = walk_color;
         px.last    = at_end;
         if (at_end) begin
            walk_active = 1'b0;
         end else begin
            // Move along the major axis; the minor one moves past the midpoint
            go_minor = (walk_decision > 0);
            if (go_minor)
               walk_decision = DECISION_W'(int'(walk_decision)
                                           + 2 * (int'(span_minor) - int'(span_major)));
            else
               walk_decision = DECISION_W'(int'(walk_decision) + 2 * int'(span_minor));
            if (y_major) begin
               walk_y = y_down ? walk_y - 1'b1 : walk_y + 1'b1;
               if (go_minor) walk_x = walk_x + 1'b1;
            end else begin
               walk_x = walk_x + 1'b1;
               if (go_minor) walk_y = y_down ? walk_y - 1'b1 : walk_y + 1'b1;
            end
         end
      end
   endtask

   // Send one request, with a random gap ahead of it
   task automatic send_request(input kind_type kind, input logic [REQ_DATA_W-1:0] data);
      pixel_type px;
      bit        made;
      bit        accepted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do begin
         @(negedge clock);
         accepted = req_tready;
         @(posedge clock);
      end while (!accepted);
      predict_request(kind, data, made, px);
      if (made) pixel_q.push_back(px);
      counted_items++;
   endtask

   // Load a line, then issue a given number of step requests
   task automatic draw_line(input int xs, input int ys, input int xe, input int ye,
                            input logic [COLOR_W-1:0] color, input int steps);
      send_request(KIND_LOAD, pack_line(xs, ys, xe, ye, color));
      repeat (steps) send_request(KIND_STEP, random_payload());
   endtask

   // Hold off the sender until every pixel has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_idle_step();
      send_request(KIND_STEP, random_payload());
   endtask

   // One-pixel line, then a step once the line is done
   task automatic test_single_point();
      draw_line(511, 0, 511, 0, 24'hFFFFFF, 2);
   endtask

   // Horizontal run given right to left, vertical run given bottom to top
   task automatic test_axis_runs();
      draw_line(511, 511, 509, 511, 24'h000000, 3);
      draw_line(0, 2, 0, 0, 24'hA5A5A5, 3);
   endtask

   // Slope exactly one with rows decreasing, and a steep line going up the screen
   task automatic test_octants();
      draw_line(0, 2, 2, 0, 24'h5A5A5A, 3);
      draw_line(5, 0, 4, 3, 24'h123456, 4);
   endtask

   // Abandon a line midway, then a line whose midpoints sit on the line
   task automatic test_reload_and_tie();
      draw_line(10, 10, 20, 14, 24'hFEDCBA, 2);
      draw_line(0, 0, 4, 2, 24'h0F0F0F, 5);
   endtask

   // Random lines, mostly short and well formed, with some noise
   task automatic test_random_lines(input int target);
      int first_count, xs, ys, xe, ye, pixels, steps, dx, dy;
      first_count = counted_items;
      while (counted_items - first_count < target) begin
         if ($urandom_range(99) < 85) begin
            xs = $urandom_range(SCREEN_SIZE - 1);
            ys = $urandom_range(SCREEN_SIZE - 1);
            if ($urandom_range(99) < 3) begin
               xe = $urandom_range(SCREEN_SIZE - 1);
               ye = $urandom_range(SCREEN_SIZE - 1);
            end else begin
               xe = clip_coord(xs + $urandom_range(24) - 12);
               ye = clip_coord(ys + $urandom_range(24) - 12);
            end
            dx     = (xe > xs) ? xe - xs : xs - xe;
            dy     = (ye > ys) ? ye - ys : ys - ye;
            pixels = ((dx > dy) ? dx : dy) + 1;
            if ($urandom_range(99) < 10)
               steps = $urandom_range(pixels - 1);
            else
               steps = pixels + $urandom_range(2);
            draw_line(xs, ys, xe, ye, COLOR_W'($urandom), steps);
         end else begin
            repeat ($urandom_range(1, 3))
               send_request(kind_type'($urandom_range(1)), random_payload());
         end
      end
   endtask

   // Compare each returned pixel with the oldest pending one
   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(negedge clock) begin : check_pixel
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            $display("%0t ns: unexpected pixel, expected none, actual 0x%0h last %0b",
                     $time, rsp_tdata, rsp_tlast);
            failed = 1'b1;
         end else begin
            want = pixel_q.pop_front();
            check_field("pixel_x", want.x, rsp_tdata[8:0]);
            check_field("pixel_y", want.y, rsp_tdata[17:9]);
            check_field("pixel_address", want.address, rsp_tdata[35:18]);
            check_field("pixel_color", want.color, rsp_tdata[59:36]);
            check_field("last", want.last, rsp_tlast);
         end
      end
   end

   initial begin
      walk_x        = '0;
      walk_y        = '0;
      stop_x        = '0;
      stop_y        = '0;
      span_major    = '0;
      span_minor    = '0;
      walk_decision = '0;
      y_major       = 1'b0;
      y_down        = 1'b0;
      walk_color    = '0;
      walk_active   = 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 81;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_idle_step();
      test_single_point();
      test_axis_runs();
      test_octants();
      test_reload_and_tie();
      test_random_lines(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 81;
      recv_idle_pct = 24;
      test_random_lines(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_lines(PHASE_ITEMS);
      wait_drained();

      if (!failed && pixel_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
